/* design/lrupr_pkg.sv */
`default_nettype none

package lrupr_pkg;

   // fixed field widths of the stream and register ports
   localparam int PAGE_FIELD_W  = 16;
   localparam int FRAME_FIELD_W = 3;
   localparam int FAULT_W       = 32;
   localparam int CSR_W         = 4;
   localparam int RSP_PAD_W     = 3;

   // frame count after reset, before clamping to the frames built
   localparam logic [CSR_W-1:0] RESET_FRAMES = CSR_W'(4);
   localparam logic [CSR_W-1:0] MIN_FRAMES   = CSR_W'(1);

   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // result beat, last field in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0]     pad;
      logic [FAULT_W-1:0]       fault_count;
      logic [PAGE_FIELD_W-1:0]  evicted_page;
      logic                     evicted_valid;
      logic [FRAME_FIELD_W-1:0] frame;
      logic                     hit;
   } rsp_beat_type;

   localparam int RSP_TDATA_W = $bits(rsp_beat_type);

   // written count to active count: zero acts as one, above the frames built saturates
   function automatic logic [CSR_W-1:0] clamp_frames(input logic [CSR_W-1:0] value,
                                                     input int frames);
      logic [CSR_W-1:0] result;
      if (value == '0) begin
         result = MIN_FRAMES;
      end else if (int'(value) > frames) begin
         result = CSR_W'(frames);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* design/lrupr_select.sv */
`default_nettype none

module lrupr_select #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16,
   parameter int IDX_W     = $clog2(FRAMES)
) (
   input  wire logic [PAGE_BITS-1:0]              page,
   input  wire logic [FRAMES-1:0][PAGE_BITS-1:0]  frame_pages,
   input  wire logic [FRAMES-1:0]                 frame_valid,
   input  wire logic [FRAMES-1:0][IDX_W-1:0]      frame_rank,
   input  wire logic [lrupr_pkg::CSR_W-1:0]       active_frames,
   output logic                                   hit,
   output logic [IDX_W-1:0]                       sel_idx,
   output logic                                   evict_valid,
   output logic [PAGE_BITS-1:0]                   evict_page
);
   import lrupr_pkg::*;

   logic [FRAMES-1:0] active;
   logic [FRAMES-1:0] match;
   logic [FRAMES-1:0] oldest;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  victim_idx;
   logic [IDX_W-1:0]  lru_rank;

   // the least recently used frame holds the top rank of the active set
   assign lru_rank = IDX_W'(active_frames - MIN_FRAMES);

   // per-frame tag compare and top-rank detect
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         active[i] = i < int'(active_frames);
         match[i]  = active[i] && frame_valid[i] && (frame_pages[i] == page);
         oldest[i] = active[i] && (frame_rank[i] == lru_rank);
      end
   end

   // priority encoders, lowest index wins
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (oldest[i]) begin
            victim_idx = IDX_W'(i);
         end
      end
   end

   // chosen frame and the page it gives up
   always_comb begin
      hit         = |match;
      sel_idx     = hit ? hit_idx : victim_idx;
      evict_valid = !hit && frame_valid[victim_idx];
      evict_page  = evict_valid ? frame_pages[victim_idx] : '0;
   end

endmodule

`default_nettype wire

/* design/lrupr_frames.sv */
`default_nettype none

module lrupr_frames #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16,
   parameter int IDX_W     = $clog2(FRAMES)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [lrupr_pkg::CSR_W-1:0]       csr_wr_data,
   input  wire logic                              update,
   input  wire logic [PAGE_BITS-1:0]              page,
   input  wire logic                              hit,
   input  wire logic [IDX_W-1:0]                  sel_idx,
   output logic [FRAMES-1:0][PAGE_BITS-1:0]       frame_pages,
   output logic [FRAMES-1:0]                      frame_valid,
   output logic [FRAMES-1:0][IDX_W-1:0]           frame_rank,
   output logic [lrupr_pkg::CSR_W-1:0]            active_frames
);
   import lrupr_pkg::*;

   logic [FRAMES-1:0][PAGE_BITS-1:0] pages_ff, pages_in;
   logic [FRAMES-1:0]                valid_ff, valid_in;
   logic [FRAMES-1:0][IDX_W-1:0]     rank_ff,  rank_in;
   logic [CSR_W-1:0]                 count_ff, count_in;
   logic [CSR_W-1:0]                 clear_count;
   logic [IDX_W-1:0]                 sel_rank;

   // a register write or reset restarts from empty frames
   assign clear_count = reset ? clamp_frames(RESET_FRAMES, FRAMES)
                              : clamp_frames(csr_wr_data, FRAMES);
   assign sel_rank    = rank_ff[sel_idx];

   // next frame contents and recency ranks
   always_comb begin
      pages_in = pages_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      if (reset || csr_wr_en) begin
         count_in = clear_count;
         valid_in = '0;
         for (int i = 0; i < FRAMES; i++) begin
            pages_in[i] = '0;
            rank_in[i]  = (i < int'(clear_count)) ? IDX_W'(int'(clear_count) - 1 - i) : '0;
         end
      end else if (update) begin
         if (!hit) begin
            pages_in[sel_idx] = page;
            valid_in[sel_idx] = 1'b1;
         end
         for (int i = 0; i < FRAMES; i++) begin
            if (i < int'(count_ff)) begin
               if (IDX_W'(i) == sel_idx) begin
                  rank_in[i] = '0;
               end else if (rank_ff[i] < sel_rank) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      rank_ff  <= rank_in;
      count_ff <= count_in;
   end

   // page tags
   always_ff @(posedge clock) begin
      pages_ff <= pages_in;
   end

   assign frame_pages   = pages_ff;
   assign frame_valid   = valid_ff;
   assign frame_rank    = rank_ff;
   assign active_frames = count_ff;

endmodule

`default_nettype wire

/* design/lru_page_replacement_top.sv */
// channel | direction | beat contents (low bit first)
// req_    | in        | tdata: page_number[15:0]
// rsp_    | out       | tdata: hit, frame[2:0], evicted_valid, evicted_page[15:0],
//         |           |        fault_count[31:0], zero pad[2:0]
// csr_    | in        | wr_data: frames_in_use[3:0], taken when wr_en is high
//
// one page reference per cycle; its result is registered and appears the next cycle
// tag compare, victim pick and rank update of active frames share the same cycle
// req_tready falls only while a result waits on a stalled rsp_ side or during reset
// reset empties all frames, sets four frames in use and clears the fault count
// a register write empties the frames and restarts the ranks; the fault count stays
`default_nettype none

module lru_page_replacement_top #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [lrupr_pkg::CSR_W-1:0]        csr_wr_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // page_number[15:0]
   input  wire logic [lrupr_pkg::PAGE_FIELD_W-1:0] req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hit, frame[2:0], evicted_valid, evicted_page[15:0], fault_count[31:0], pad[2:0]
   output logic [lrupr_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import lrupr_pkg::*;

   localparam int IDX_W = $clog2(FRAMES);

   logic [FRAMES-1:0][PAGE_BITS-1:0] frame_pages;
   logic [FRAMES-1:0]                frame_valid;
   logic [FRAMES-1:0][IDX_W-1:0]     frame_rank;
   logic [CSR_W-1:0]                 active_frames;
   logic [PAGE_BITS-1:0]             page;
   logic                             hit;
   logic [IDX_W-1:0]                 sel_idx;
   logic                             evict_valid;
   logic [PAGE_BITS-1:0]             evict_page;
   logic                             req_beat;
   logic [FAULT_W-1:0]               faults_ff, faults_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type                     rsp_beat_ff, rsp_beat_in;

   // input handshake
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_beat   = req_tvalid && req_tready;
   assign page       = PAGE_BITS'(req_tdata);

   lrupr_select #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W)
   ) u_select (
      .page          (page),
      .frame_pages   (frame_pages),
      .frame_valid   (frame_valid),
      .frame_rank    (frame_rank),
      .active_frames (active_frames),
      .hit           (hit),
      .sel_idx       (sel_idx),
      .evict_valid   (evict_valid),
      .evict_page    (evict_page)
   );

   lrupr_frames #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W)
   ) u_frames (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .update        (req_beat),
      .page          (page),
      .hit           (hit),
      .sel_idx       (sel_idx),
      .frame_pages   (frame_pages),
      .frame_valid   (frame_valid),
      .frame_rank    (frame_rank),
      .active_frames (active_frames)
   );

   // saturating fault counter
   always_comb begin
      faults_in = faults_ff;
      if (reset) begin
         faults_in = '0;
      end else if (req_beat && !hit && faults_ff != FAULT_MAX) begin
         faults_in = faults_ff + FAULT_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (reset) begin
         rsp_valid_in = 1'b0;
      end else if (req_beat) begin
         rsp_valid_in              = 1'b1;
         rsp_beat_in.pad           = '0;
         rsp_beat_in.fault_count   = faults_in;
         rsp_beat_in.evicted_page  = PAGE_FIELD_W'(evict_page);
         rsp_beat_in.evicted_valid = evict_valid;
         rsp_beat_in.frame         = FRAME_FIELD_W'(sel_idx);
         rsp_beat_in.hit           = hit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      faults_ff    <= faults_in;
      rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_beat_ff;

endmodule

`default_nettype wire

/* design/lrupr_checker.sv */
`default_nettype none

module lrupr_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [lrupr_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import lrupr_pkg::*;

   rsp_beat_type beat;

   assign beat = rsp_tdata;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // every accepted reference yields a result beat next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted reference gave no result");

   // an eviction only comes with a fault, so the count is non-zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && beat.evicted_valid |-> !beat.hit && beat.fault_count != '0)
      else $error("eviction without a counted fault");

endmodule

bind lru_page_replacement_top lrupr_checker u_lrupr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
